// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the septet stream unpacker.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/ssu_pkg.sv -----
// Package for the septet stream unpacker: item types, widths and register indexes.
// No dependencies; used by septet_stream_unpacker_core.
`timescale 1ns / 1ps
`default_nettype none

package ssu_pkg;

  localparam int OctetW    = 8;
  localparam int SeptetW   = 7;
  localparam int ShiftW    = 3;
  localparam int CharCntW  = 10;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 10;

  // Result queue sizing: one item can push up to two results.
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;
  localparam int QCntW     = 3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegStartOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxChars    = 1'b1;

  // Register reset values.
  localparam logic [ShiftW-1:0]   StartOffsetRst = 3'd0;
  localparam logic [CharCntW-1:0] MaxCharsRst    = 10'd160;

  // Shift count used for an aligned septet.
  localparam logic [ShiftW-1:0]   FullShift      = 3'd7;

  typedef struct packed {
    logic [OctetW-1:0] octet;
    logic              last_octet;
  } in_t;

  typedef struct packed {
    logic [SeptetW-1:0] septet;
    logic               last_char;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/septet_stream_unpacker_core.sv -----
// Top level of the septet stream unpacker: unpacking datapath and result queue.
// Depends on ssu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packed octet per cycle while in_ready is high and produces 7-bit
// characters. Each accepted octet is unpacked in the cycle it is accepted and
// its results (none, one, or two after every seventh octet) are written into a
// four-entry result queue; the first result is offered on the next cycle. Input
// ready is high while the queue has room for two results, so with a free-running
// consumer the two results of a seventh octet can pause the input, the cost of the
// extra character on the single output port. Configuration writes are
// always taken; start_offset applies at the next message start, max_chars at
// once. The character limit drops the rest of a message until its last octet.
module septet_stream_unpacker_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ssu_pkg::in_t                  in_data,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ssu_pkg::out_t                      out_data,
  // Configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ssu_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [ssu_pkg::CfgDataW-1:0]  cfg_wdata
);

  import ssu_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers
  logic [ShiftW-1:0]   start_offset_r;
  logic [CharCntW-1:0] max_chars_r;

  // Message state
  logic [ShiftW-1:0]   shift_r,     shift_nxt;
  logic [SeptetW-1:0]  residue_r,   residue_nxt;
  logic                first_r,     first_nxt;
  logic [CharCntW-1:0] chars_r,     chars_nxt;
  logic                limit_r,     limit_nxt;

  // Result queue
  out_t                q_mem_r [QDepth];
  logic [QPtrW-1:0]    wr_ptr_r;
  logic [QPtrW-1:0]    rd_ptr_r;
  logic [QCntW-1:0]    count_r;

  // Datapath values
  logic                in_fire;
  logic                out_fire;
  logic [ShiftW-1:0]   bits;
  logic [OctetW+SeptetW-1:0] shifted;
  logic [SeptetW-1:0]  ch;
  logic [SeptetW-1:0]  rest;
  logic                emit0;
  logic [CharCntW-1:0] cnt1;
  logic [CharCntW-1:0] cnt2;
  logic [1:0]          push_n;
  out_t                ent0;
  out_t                ent1;
  logic [QPtrW-1:0]    wr_ptr_p1;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  // Room for two results is required before an item is taken.
  assign in_ready  = (count_r <= QCntW'(QDepth - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = q_mem_r[rd_ptr_r];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= StartOffsetRst;
      max_chars_r    <= MaxCharsRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegStartOffset: start_offset_r <= cfg_wdata[ShiftW-1:0];
        RegMaxChars:    max_chars_r    <= cfg_wdata[CharCntW-1:0];
        default:        ;
      endcase
    end
  end

  // Unpack one octet: complete the pending character, keep the high bits
  // as the new residue, and emit the residue itself once it holds seven bits.
  always_comb begin
    shift_nxt   = shift_r;
    residue_nxt = residue_r;
    first_nxt   = first_r;
    chars_nxt   = chars_r;
    limit_nxt   = limit_r || (chars_r >= max_chars_r);
    push_n      = 2'd0;
    ent0        = '0;
    ent1        = '0;
    cnt2        = '0;

    if (first_r) begin
      bits = (start_offset_r != '0) ? start_offset_r : FullShift;
    end else begin
      bits = shift_r;
    end
    if (bits == '0) begin
      bits = FullShift;
    end

    // Low octet bits land above the residue bits; high bits are cut off.
    shifted = (OctetW+SeptetW)'(in_data.octet) << (FullShift - bits);
    ch      = shifted[SeptetW-1:0] | residue_r;
    rest    = SeptetW'(in_data.octet >> bits);
    emit0   = !first_r || (bits == FullShift);
    cnt1    = chars_r + CharCntW'(emit0);

    if (!limit_nxt) begin
      first_nxt = 1'b0;
      chars_nxt = cnt1;
      if (emit0) begin
        ent0.septet = ch;
        push_n      = 2'd1;
      end

      if (cnt1 >= max_chars_r) begin
        // Limit reached on the first character; flag it as the last one.
        limit_nxt      = 1'b1;
        ent0.last_char = emit0;
        shift_nxt      = bits;
        residue_nxt    = rest;
      end else if (bits == 3'd1) begin
        // Seventh octet: the residue is a whole character of its own.
        cnt2        = cnt1 + CharCntW'(1);
        chars_nxt   = cnt2;
        shift_nxt   = FullShift;
        residue_nxt = '0;
        if (emit0) begin
          ent1.septet    = rest;
          ent1.last_char = (cnt2 >= max_chars_r);
          push_n         = 2'd2;
        end else begin
          ent0.septet    = rest;
          ent0.last_char = (cnt2 >= max_chars_r);
          push_n         = 2'd1;
        end
        limit_nxt = (cnt2 >= max_chars_r);
      end else begin
        shift_nxt   = bits - ShiftW'(1);
        residue_nxt = rest;
      end
    end

    // The final octet flags its last result and restarts the message.
    if (in_data.last_octet) begin
      if (push_n == 2'd2) begin
        ent1.last_char = 1'b1;
      end else if (push_n == 2'd1) begin
        ent0.last_char = 1'b1;
      end
      shift_nxt   = FullShift;
      residue_nxt = '0;
      first_nxt   = 1'b1;
      chars_nxt   = '0;
      limit_nxt   = 1'b0;
    end
  end

  // Message state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= FullShift;
      residue_r <= '0;
      first_r   <= 1'b1;
      chars_r   <= '0;
      limit_r   <= 1'b0;
    end else if (in_fire) begin
      shift_r   <= shift_nxt;
      residue_r <= residue_nxt;
      first_r   <= first_nxt;
      chars_r   <= chars_nxt;
      limit_r   <= limit_nxt;
    end
  end

  // Result queue storage.
  assign wr_ptr_p1 = wr_ptr_r + QPtrW'(1);

  always_ff @(posedge clk) begin
    if (in_fire && (push_n != 2'd0)) begin
      q_mem_r[wr_ptr_r] <= ent0;
    end
    if (in_fire && (push_n == 2'd2)) begin
      q_mem_r[wr_ptr_p1] <= ent1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + QPtrW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      count_r <= count_r + QCntW'(in_fire ? push_n : 2'd0) - QCntW'(out_fire);
    end
  end

  // Checks on the queue and the unpacking state.
  `ASSERT_ALWAYS(a_queue_bound, count_r <= QCntW'(QDepth))
  `ASSERT_ALWAYS(a_shift_nonzero, shift_r != '0)
  `ASSERT_NEXT(a_limited_silent, in_fire && limit_r && !in_data.last_octet,
               count_r <= $past(count_r))
  `ASSERT_IMPLIES(a_first_clean, first_r, residue_r == '0 && chars_r == '0)

endmodule

`default_nettype wire
